>>> design/spo2_pkg.sv
package spo2_pkg;

  localparam int SAMPLE_BITS = 18;
  localparam int WLEN_W      = 6;
  localparam int THR_W       = 19;
  localparam int CFG_DATA_W  = 19;
  localparam int CFG_IDX_W   = 2;
  localparam int OUT_W       = 24;

  // ratio format: unsigned Q8.16
  localparam int R_W    = 24;
  localparam int FRAC_W = 16;
  localparam int DSH    = R_W - FRAC_W;
  localparam int NUM_W  = 2 * SAMPLE_BITS;
  localparam int SUM_W  = (SAMPLE_BITS + 1 > THR_W) ? SAMPLE_BITS + 1 : THR_W;

  // shared multiplier
  localparam int MUL_A_W = 24;
  localparam int MUL_B_W = 32;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W;
  localparam int DIV_CNT_W = $clog2(R_W);

  localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(40);
  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(20000);

  // Q16 coefficients
  localparam logic [MUL_A_W-1:0] COEF_SQ    = MUL_A_W'(2953052);
  localparam logic [MUL_A_W-1:0] COEF_LIN   = MUL_A_W'(1989280);
  localparam logic [MUL_A_W-1:0] COEF_CONST = MUL_A_W'(6215762);

  // constant term in Q32 plus the half LSB for rounding to Q8
  localparam logic signed [ACC_W-1:0] ACC_INIT =
    (ACC_W'(COEF_CONST) << FRAC_W) + (ACC_W'(1) << 23);

  localparam logic signed [ACC_W-25:0] Q_MAX = (ACC_W-24)'(8388607);
  localparam logic signed [ACC_W-25:0] Q_MIN = -(ACC_W-24)'(8388608);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH      = 2'd0,
    CFG_PRESENCE_THRESHOLD = 2'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_LOW  = 2'd1,
    ST_DIV0 = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_NUM,
    S_MUL_DEN,
    S_DIV_INIT,
    S_DIV,
    S_MUL_SQ,
    S_MUL_R2C,
    S_ACC_SQ,
    S_ACC_LIN,
    S_ROUND,
    S_PUSH
  } state_t;

endpackage

>>> design/spo2_ratio_window_estimator.sv
// SpO2 ratio-of-ratios window estimator.
// Input channel: in_valid/in_ready carry one pair of LED samples per transfer.
// Result channel: out_valid/out_ready carry out_spo2_estimate (signed Q15.8)
// and out_status (ok, low signal, divide by zero).
// Configuration: cfg_we writes cfg_wdata into register cfg_index at the clock
// edge (0: window length, 1: presence threshold); other indexes are ignored.
// A pair that does not close the window gives no result and leaves the
// sequencer idle. A low-signal pair's result goes through S_PUSH into the
// output register before the next pair is taken. A pair that closes the
// window runs the shared 24x32 multiplier five times and a restoring divider,
// one quotient bit per cycle, and the next pair is taken only after the result
// has gone into the output register. A zero divisor or a clipped ratio skips
// the divider loop.
// in_ready is high only while the sequencer idles; a finished result sits in
// the output register, so new pairs are taken while it waits. When the
// receiver stalls with a result still held, the next result waits in the
// sequencer and in_ready stays low until the output register frees up.
// Synchronous reset empties the window, drops any pending result and restores
// window length 40 and threshold 20000.
module spo2_ratio_window_estimator (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [spo2_pkg::SAMPLE_BITS-1:0]        in_first_sample,
  input  logic [spo2_pkg::SAMPLE_BITS-1:0]        in_second_sample,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [spo2_pkg::OUT_W-1:0]       out_spo2_estimate,
  output spo2_pkg::status_t                       out_status,
  input  logic                                    cfg_we,
  input  logic [spo2_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [spo2_pkg::CFG_DATA_W-1:0]         cfg_wdata
);
  import spo2_pkg::*;

  state_t state_r, state_nxt;

  logic [WLEN_W-1:0]      wlen_r, wlen_nxt;
  logic [THR_W-1:0]       thr_r, thr_nxt;
  logic [WLEN_W-1:0]      count_r, count_nxt;
  logic [SAMPLE_BITS-1:0] fmax_r, fmax_nxt, fmin_r, fmin_nxt;
  logic [SAMPLE_BITS-1:0] smax_r, smax_nxt, smin_r, smin_nxt;

  logic [NUM_W-1:0]       num_r, num_nxt, den_r, den_nxt, rem_r, rem_nxt;
  logic [R_W-1:0]         dlo_r, dlo_nxt, ratio_r, ratio_nxt;
  logic [DIV_CNT_W-1:0]   dcnt_r, dcnt_nxt;
  logic [PROD_W-1:0]      prod_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;

  logic [OUT_W-1:0]       res_est_r, res_est_nxt;
  status_t                res_st_r, res_st_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]       out_est_r, out_est_nxt;
  status_t                out_st_r, out_st_nxt;

  logic                   accept;
  logic [SUM_W-1:0]       pair_sum;
  logic                   low_sig;
  logic [WLEN_W-1:0]      count_inc;
  logic                   win_done;
  logic [SAMPLE_BITS-1:0] acf, acs;
  logic                   den_zero, ratio_sat;
  logic [NUM_W:0]         div_trial;
  logic                   div_ge;
  logic                   out_free;
  logic signed [ACC_W-25:0] q_val;
  logic [MUL_A_W-1:0]     mul_a;
  logic [MUL_B_W-1:0]     mul_b;

  assign accept    = in_valid && in_ready;
  assign pair_sum  = SUM_W'(in_first_sample) + SUM_W'(in_second_sample);
  assign low_sig   = pair_sum < SUM_W'(thr_r);
  assign count_inc = count_r + WLEN_W'(1);
  assign win_done  = (count_inc == '0) || (count_inc >= wlen_r);
  assign acf       = fmax_r - fmin_r;
  assign acs       = smax_r - smin_r;
  assign den_zero  = (prod_r[NUM_W-1:0] == '0);
  // the divisor is still on the multiplier output here
  assign ratio_sat = {{DSH{1'b0}}, num_r} >= {prod_r[NUM_W-1:0], {DSH{1'b0}}};
  assign div_trial = {rem_r, dlo_r[R_W-1]};
  assign div_ge    = div_trial >= {1'b0, den_r};
  assign out_free  = !out_valid_r || out_ready;
  assign q_val     = acc_r[ACC_W-1:24];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (low_sig) begin
            state_nxt = S_PUSH;
          end else if (win_done) begin
            state_nxt = S_MUL_NUM;
          end
        end
      end
      S_MUL_NUM:  state_nxt = S_MUL_DEN;
      S_MUL_DEN:  state_nxt = S_DIV_INIT;
      S_DIV_INIT: begin
        if (den_zero) begin
          state_nxt = S_PUSH;
        end else if (ratio_sat) begin
          state_nxt = S_MUL_SQ;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (dcnt_r == '0) begin
          state_nxt = S_MUL_SQ;
        end
      end
      S_MUL_SQ:   state_nxt = S_MUL_R2C;
      S_MUL_R2C:  state_nxt = S_ACC_SQ;
      S_ACC_SQ:   state_nxt = S_ACC_LIN;
      S_ACC_LIN:  state_nxt = S_ROUND;
      S_ROUND:    state_nxt = S_PUSH;
      S_PUSH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs: handshake and multiplier operand select
  always_comb begin
    in_ready = (state_r == S_IDLE);
    mul_a    = '0;
    mul_b    = '0;
    case (state_r)
      S_MUL_NUM: begin
        mul_a = MUL_A_W'(acs);
        mul_b = MUL_B_W'(fmin_r);
      end
      S_MUL_DEN: begin
        mul_a = MUL_A_W'(acf);
        mul_b = MUL_B_W'(smin_r);
      end
      S_MUL_SQ: begin
        mul_a = ratio_r;
        mul_b = MUL_B_W'(ratio_r);
      end
      S_MUL_R2C: begin
        mul_a = COEF_SQ;
        mul_b = prod_r[2*R_W-1:FRAC_W];
      end
      S_ACC_SQ: begin
        mul_a = COEF_LIN;
        mul_b = MUL_B_W'(ratio_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // datapath
  always_comb begin
    wlen_nxt    = wlen_r;
    thr_nxt     = thr_r;
    count_nxt   = count_r;
    fmax_nxt    = fmax_r;
    fmin_nxt    = fmin_r;
    smax_nxt    = smax_r;
    smin_nxt    = smin_r;
    num_nxt     = num_r;
    den_nxt     = den_r;
    rem_nxt     = rem_r;
    dlo_nxt     = dlo_r;
    ratio_nxt   = ratio_r;
    dcnt_nxt    = dcnt_r;
    acc_nxt     = acc_r;
    res_est_nxt = res_est_r;
    res_st_nxt  = res_st_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_LENGTH:      wlen_nxt = cfg_wdata[WLEN_W-1:0];
        CFG_PRESENCE_THRESHOLD: thr_nxt  = cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (low_sig) begin
            count_nxt   = '0;
            res_est_nxt = '0;
            res_st_nxt  = ST_LOW;
          end else begin
            if (count_r == '0) begin
              fmax_nxt = in_first_sample;
              fmin_nxt = in_first_sample;
              smax_nxt = in_second_sample;
              smin_nxt = in_second_sample;
            end else begin
              if (in_first_sample > fmax_r)  fmax_nxt = in_first_sample;
              if (in_first_sample < fmin_r)  fmin_nxt = in_first_sample;
              if (in_second_sample > smax_r) smax_nxt = in_second_sample;
              if (in_second_sample < smin_r) smin_nxt = in_second_sample;
            end
            count_nxt = win_done ? '0 : count_inc;
          end
        end
      end
      S_MUL_DEN: begin
        num_nxt = prod_r[NUM_W-1:0];
      end
      S_DIV_INIT: begin
        den_nxt  = prod_r[NUM_W-1:0];
        rem_nxt  = NUM_W'(num_r >> DSH);
        dlo_nxt  = {num_r[DSH-1:0], {FRAC_W{1'b0}}};
        dcnt_nxt = DIV_CNT_W'(R_W - 1);
        if (den_zero) begin
          res_est_nxt = '0;
          res_st_nxt  = ST_DIV0;
        end else if (ratio_sat) begin
          ratio_nxt = '1;
        end
      end
      S_DIV: begin
        // one quotient bit per cycle
        rem_nxt   = div_ge ? NUM_W'(div_trial - {1'b0, den_r}) : div_trial[NUM_W-1:0];
        ratio_nxt = {ratio_r[R_W-2:0], div_ge};
        dlo_nxt   = {dlo_r[R_W-2:0], 1'b0};
        dcnt_nxt  = dcnt_r - DIV_CNT_W'(1);
      end
      S_MUL_SQ: begin
        acc_nxt = ACC_INIT;
      end
      S_ACC_SQ: begin
        acc_nxt = acc_r - $signed(prod_r);
      end
      S_ACC_LIN: begin
        acc_nxt = acc_r + $signed(prod_r);
      end
      S_ROUND: begin
        res_st_nxt = ST_OK;
        if (q_val > Q_MAX) begin
          res_est_nxt = OUT_W'(Q_MAX);
        end else if (q_val < Q_MIN) begin
          res_est_nxt = OUT_W'(Q_MIN);
        end else begin
          res_est_nxt = q_val[OUT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_est_nxt   = out_est_r;
    out_st_nxt    = out_st_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == S_PUSH && out_free) begin
      out_valid_nxt = 1'b1;
      out_est_nxt   = res_est_r;
      out_st_nxt    = res_st_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wlen_r      <= WLEN_RESET;
      thr_r       <= THR_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wlen_r      <= wlen_nxt;
      thr_r       <= thr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fmax_r    <= fmax_nxt;
    fmin_r    <= fmin_nxt;
    smax_r    <= smax_nxt;
    smin_r    <= smin_nxt;
    num_r     <= num_nxt;
    den_r     <= den_nxt;
    rem_r     <= rem_nxt;
    dlo_r     <= dlo_nxt;
    ratio_r   <= ratio_nxt;
    dcnt_r    <= dcnt_nxt;
    prod_r    <= mul_a * mul_b;
    acc_r     <= acc_nxt;
    res_est_r <= res_est_nxt;
    res_st_r  <= res_st_nxt;
    out_est_r <= out_est_nxt;
    out_st_r  <= out_st_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_spo2_estimate = $signed(out_est_r);
  assign out_status        = out_st_r;

endmodule

>>> design/spo2_chk.sv
module spo2_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [spo2_pkg::OUT_W-1:0] out_spo2_estimate,
  input spo2_pkg::status_t                 out_status
);
  import spo2_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_spo2_estimate)
      && $stable(out_status))
    else $error("result changed while stalled");

  // any non-ok status carries a zero estimate
  a_zero_on_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_LOW || out_status == ST_DIV0)
      |-> out_spo2_estimate == '0)
    else $error("nonzero estimate with error status");

  // a new result is loaded only by the busy sequencer
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result loaded while sequencer idle");

endmodule

bind spo2_ratio_window_estimator spo2_chk u_spo2_chk (.*);

>>> tb/testbench.sv
module testbench;
  import spo2_pkg::*;

  localparam int          SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;
  localparam int          SETTLE_CYCLES = 48;
  localparam int          LONG_STALL    = 400;
  localparam longint      RUN_LIMIT     = 1000000;
  localparam longint      Q16_SQ        = 2953052;
  localparam longint      Q16_LIN       = 1989280;
  localparam longint      Q16_CONST     = 6215762;
  localparam longint      RATIO_CEIL    = 64'hFFFFFF;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct {
    logic signed [OUT_W-1:0] estimate;
    status_t                 status;
  } spo2_result_t;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [SAMPLE_BITS-1:0]        in_first_sample;
  logic [SAMPLE_BITS-1:0]        in_second_sample;
  logic                          out_valid;
  logic                          out_ready;
  logic signed [OUT_W-1:0]       out_spo2_estimate;
  status_t                       out_status;
  logic                          cfg_we;
  logic [CFG_IDX_W-1:0]          cfg_index;
  logic [CFG_DATA_W-1:0]         cfg_wdata;

  // mirror of the block's registers and window tracking
  logic [WLEN_W-1:0]      win_len      = WLEN_W'(40);
  logic [THR_W-1:0]       presence_min = THR_W'(20000);
  logic [WLEN_W-1:0]      pair_count   = '0;
  logic [SAMPLE_BITS-1:0] first_hi = '0, first_lo = '0, second_hi = '0, second_lo = '0;

  spo2_result_t pending_estimates[$];
  int           errors = 0;
  longint       cycles = 0;
  bit           tx_quiet = 1'b0;
  bit           rx_quiet = 1'b0;
  bit           hold_request = 1'b0;

  // shape of the current random window
  int unsigned base_first, base_second, swing_first, swing_second;
  bit          flat_first, floor_second;

  spo2_ratio_window_estimator DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_first_sample   (in_first_sample),
    .in_second_sample  (in_second_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_spo2_estimate (out_spo2_estimate),
    .out_status        (out_status),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic signed [OUT_W-1:0] ratio_to_spo2(input longint ratio);
    longint sq, acc, q;
    sq  = (ratio * ratio) >>> 16;
    acc = Q16_LIN * ratio - Q16_SQ * sq + (Q16_CONST <<< 16);
    // round the Q32 sum to Q8
    q = (acc + (longint'(1) <<< 23)) >>> 24;
    if (q > 8388607)
      q = 8388607;
    else if (q < -8388608)
      q = -8388608;
    return q[OUT_W-1:0];
  endfunction

  task automatic track_pair(input logic [SAMPLE_BITS-1:0] a, input logic [SAMPLE_BITS-1:0] b);
    spo2_result_t r;
    longint       acf, acs, num, den, ratio;
    if ((20'(a) + 20'(b)) < 20'(presence_min)) begin
      pair_count = '0;
      r.estimate = '0;
      r.status   = ST_LOW;
      pending_estimates.push_back(r);
      return;
    end
    if (pair_count == 0) begin
      first_hi  = a;
      first_lo  = a;
      second_hi = b;
      second_lo = b;
    end else begin
      if (a > first_hi)  first_hi  = a;
      if (a < first_lo)  first_lo  = a;
      if (b > second_hi) second_hi = b;
      if (b < second_lo) second_lo = b;
    end
    pair_count = pair_count + 1'b1;
    if (pair_count != 0 && pair_count < win_len)
      return;
    pair_count = '0;
    acf = longint'(first_hi) - longint'(first_lo);
    acs = longint'(second_hi) - longint'(second_lo);
    num = acs * longint'(first_lo);
    den = acf * longint'(second_lo);
    if (den == 0) begin
      r.estimate = '0;
      r.status   = ST_DIV0;
    end else begin
      ratio = (num <<< 16) / den;
      if (ratio > RATIO_CEIL)
        ratio = RATIO_CEIL;
      r.estimate = ratio_to_spo2(ratio);
      r.status   = ST_OK;
    end
    pending_estimates.push_back(r);
  endtask

  always @(posedge clk) begin : check_results
    spo2_result_t due;
    if (rst_n && out_valid && out_ready) begin
      if (pending_estimates.size() == 0) begin
        $error("unexpected result: spo2_estimate %0d status %0d", out_spo2_estimate,
               out_status);
        errors++;
      end else begin
        due = pending_estimates.pop_front();
        if (out_spo2_estimate !== due.estimate) begin
          $error("spo2_estimate: expected %0d, got %0d", due.estimate, out_spo2_estimate);
          errors++;
        end
        if (out_status !== due.status) begin
          $error("status: expected %0d, got %0d", due.status, out_status);
          errors++;
        end
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int unsigned pause;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      pause = rx_quiet ? 0 : $urandom_range(0, 16);
      if (hold_request) begin
        pause        = LONG_STALL;
        hold_request = 1'b0;
      end
      repeat (pause) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // leave in_valid high after the transfer; the next call lowers it only for a gap
  task automatic send_pair(input logic [SAMPLE_BITS-1:0] a, input logic [SAMPLE_BITS-1:0] b);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_first_sample  <= a;
    in_second_sample <= b;
    do @(posedge clk); while (!in_ready);
    track_pair(a, b);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_WINDOW_LENGTH)
      win_len = data[WLEN_W-1:0];
    else if (idx == CFG_PRESENCE_THRESHOLD)
      presence_min = data[THR_W-1:0];
  endtask

  function automatic logic [SAMPLE_BITS-1:0] wobble(input int unsigned base,
                                                     input int unsigned swing);
    int unsigned v;
    v = base + $urandom_range(0, swing);
    if (v > SAMPLE_MAX)
      v = SAMPLE_MAX;
    return v[SAMPLE_BITS-1:0];
  endfunction

  task automatic pick_pair(output logic [SAMPLE_BITS-1:0] a, output logic [SAMPLE_BITS-1:0] b);
    int unsigned pick, lo, low_cut;
    // draw a new waveform shape at each window start
    if (pair_count == 0) begin
      lo           = presence_min >> 1;
      base_first   = $urandom_range(SAMPLE_MAX, lo);
      base_second  = $urandom_range(SAMPLE_MAX, lo);
      swing_first  = $urandom_range(1, 6000);
      swing_second = $urandom_range(1, 6000);
      flat_first   = ($urandom_range(0, 19) == 0);
      floor_second = ($urandom_range(0, 24) == 0);
    end
    low_cut = (win_len > 16) ? 1 : 3;
    pick    = $urandom_range(0, 99);
    if (pick < low_cut) begin
      a = SAMPLE_BITS'($urandom_range(0, 255));
      b = SAMPLE_BITS'($urandom_range(0, 255));
    end else if (pick < 12) begin
      a = SAMPLE_BITS'($urandom);
      b = SAMPLE_BITS'($urandom);
    end else begin
      a = flat_first ? base_first[SAMPLE_BITS-1:0] : wobble(base_first, swing_first);
      b = (floor_second && pick < 30) ? '0 : wobble(base_second, swing_second);
    end
  endtask

  task automatic run_phase(input logic [WLEN_W-1:0] wl, input logic [THR_W-1:0] thr,
                           input int n, input bit quiet_tx, input bit quiet_rx);
    logic [SAMPLE_BITS-1:0] a, b;
    write_reg(CFG_WINDOW_LENGTH, {13'($urandom), wl});
    write_reg(CFG_PRESENCE_THRESHOLD, thr);
    tx_quiet = quiet_tx;
    rx_quiet = quiet_rx;
    repeat (n) begin
      pick_pair(a, b);
      send_pair(a, b);
    end
    wait_idle();
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // reset settings: low pair first, at the threshold edge, and mid-window
  task automatic test_low_signal();
    send_pair('0, '0);
    send_pair(18'd10000, 18'd9999);
    send_pair(18'd10000, 18'd10000);
    send_pair('0, '0);
    wait_idle();
  endtask

  task automatic test_window_close();
    write_reg(CFG_WINDOW_LENGTH, {13'h1ABC, 6'd2});
    send_pair(18'h3FFFF, 18'h3FFFF);
    send_pair(18'h3FFFF, 18'h3FFFF);
    send_pair(18'd100000, 18'd120000);
    send_pair(18'd104000, 18'd118000);
    // tiny first-channel swing against a huge second one: ratio clips
    send_pair(18'd262142, 18'd1);
    send_pair(18'h3FFFF, 18'h3FFFF);
    // zero first-channel floor: ratio of zero
    send_pair('0, 18'h3FFFF);
    send_pair(18'h3FFFF, 18'h3FFFF);
    wait_idle();
  endtask

  task automatic test_zero_divisor();
    write_reg(CFG_PRESENCE_THRESHOLD, '0);
    send_pair('0, '0);
    send_pair('0, '0);
    send_pair(18'd10, '0);
    send_pair(18'd20, 18'd5);
    wait_idle();
  endtask

  task automatic test_short_window();
    write_reg(CFG_WINDOW_LENGTH, {13'h0000, 6'd0});
    send_pair(18'd1, 18'd2);
    send_pair(18'd3, 18'd4);
    wait_idle();
    write_reg(CFG_WINDOW_LENGTH, {13'h1FFF, 6'd1});
    send_pair(18'h3FFFF, '0);
    send_pair(18'd7, 18'd9);
    wait_idle();
  endtask

  task automatic test_spare_index();
    write_reg(CFG_SPARE_LO, 19'h00002);
    write_reg(CFG_SPARE_HI, 19'h7FFFF);
    send_pair(18'd5000, 18'd5000);
    wait_idle();
  endtask

  // hold off the receiver while pairs keep coming, so the input stalls
  task automatic test_backpressure();
    logic [SAMPLE_BITS-1:0] a, b;
    write_reg(CFG_WINDOW_LENGTH, {13'($urandom), 6'd2});
    write_reg(CFG_PRESENCE_THRESHOLD, '0);
    tx_quiet     = 1'b1;
    hold_request = 1'b1;
    repeat (40) begin
      pick_pair(a, b);
      send_pair(a, b);
    end
    wait_idle();
    tx_quiet = 1'b0;
  endtask

  task automatic test_random_traffic();
    run_phase(6'd8,  19'd20000,  400, 1'b0, 1'b0);
    run_phase(6'd2,  19'd0,      250, 1'b1, 1'b1);
    run_phase(6'd63, 19'd1000,   400, 1'b0, 1'b0);
    run_phase(6'd5,  19'd524286, 100, 1'b0, 1'b1);
    run_phase(6'd16, 19'd300000, 300, 1'b1, 1'b0);
    run_phase(6'd40, 19'd20000,  160, 1'b0, 1'b0);
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_first_sample  <= '0;
    in_second_sample <= '0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_WINDOW_LENGTH;
    cfg_wdata        <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_low_signal();
    test_window_close();
    test_zero_divisor();
    test_short_window();
    test_spare_index();
    test_backpressure();
    test_random_traffic();
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

>>> spo2_ratio_window_estimator.f
design/spo2_pkg.sv
design/spo2_ratio_window_estimator.sv
design/spo2_chk.sv
tb/testbench.sv
